// ----- rtl/core/eas_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eas_pkg
// shared widths, register indexes, score constants and the flag struct
// ----------------------------------------------------------------------------
package eas_pkg;

  // fraction bits of the fixed-point ratios
  localparam int FRAC_BITS_DEF = 16;

  // sample and baseline width
  localparam int VAL_W = 16;
  // partial remainder width: holds 4*baseline
  localparam int REM_W = VAL_W + 2;
  // score width
  localparam int ARO_W = 7;
  // integer part of the weighted sum, at most 300
  localparam int SUM_W = 9;

  // configuration port
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_TONIC_BASE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PHASIC_BASE = 2'd1;

  // score weights
  localparam int W_TONIC  = 80;
  localparam int W_PHASIC = 60;

  // floor(x/3) as (x*683) >> 11, exact for x below 1024
  localparam int DIV3_MUL_W = 10;
  localparam logic [DIV3_MUL_W-1:0] DIV3_MUL = 10'd683;
  localparam int DIV3_SHIFT = 11;

  localparam logic [ARO_W-1:0] SCORE_MAX = 7'd100;

  // per-sample override flags that ride along with the divider data
  typedef struct packed {
    logic tonic_zero;
    logic tonic_sat;
    logic phasic_zero;
    logic phasic_sat;
  } eas_flags_t;

endpackage

// ----- rtl/core/eas_in_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eas_in_if
// sample channel: tonic level and phasic rate with valid/ready
// ----------------------------------------------------------------------------
interface eas_in_if;
  logic                     valid;
  logic                     ready;
  logic [eas_pkg::VAL_W-1:0] tonic_level;
  logic [eas_pkg::VAL_W-1:0] phasic_rate;

  modport source (output valid, output tonic_level, output phasic_rate, input ready);
  modport sink (input valid, input tonic_level, input phasic_rate, output ready);
endinterface

// ----- rtl/core/eas_out_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eas_out_if
// result channel: arousal score with valid/ready
// ----------------------------------------------------------------------------
interface eas_out_if;
  logic                     valid;
  logic                     ready;
  logic [eas_pkg::ARO_W-1:0] arousal;

  modport source (output valid, output arousal, input ready);
  modport sink (input valid, input arousal, output ready);
endinterface

// ----- rtl/core/eas_div_cell.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eas_div_cell
// one restoring-division step for both ratio lanes, one pipeline stage
// ----------------------------------------------------------------------------
module eas_div_cell #(
  parameter int QW = eas_pkg::FRAC_BITS_DEF + 2
) (
  input  logic                      clk,
  input  logic                      rst_n,
  // divisors, 4*baseline, stable while samples are in flight
  input  logic [eas_pkg::REM_W-1:0] d1,
  input  logic [eas_pkg::REM_W-1:0] d2,
  // upstream neighbor
  input  logic                      up_valid,
  output logic                      up_ready,
  input  logic [eas_pkg::REM_W-1:0] up_rem1,
  input  logic [eas_pkg::REM_W-1:0] up_rem2,
  input  logic [QW-1:0]             up_q1,
  input  logic [QW-1:0]             up_q2,
  input  eas_pkg::eas_flags_t       up_flags,
  // downstream neighbor
  output logic                      dn_valid,
  input  logic                      dn_ready,
  output logic [eas_pkg::REM_W-1:0] dn_rem1,
  output logic [eas_pkg::REM_W-1:0] dn_rem2,
  output logic [QW-1:0]             dn_q1,
  output logic [QW-1:0]             dn_q2,
  output eas_pkg::eas_flags_t       dn_flags
);

  logic                      valid_r;
  logic [eas_pkg::REM_W-1:0] rem1_r, rem2_r;
  logic [QW-1:0]             q1_r, q2_r;
  eas_pkg::eas_flags_t       flags_r;

  logic [eas_pkg::REM_W:0]   sh1, sh2;
  logic                      ge1, ge2;
  logic [eas_pkg::REM_W-1:0] rem1_nxt, rem2_nxt;

  // shift, compare, conditional subtract
  always_comb begin
    sh1 = {up_rem1, 1'b0};
    sh2 = {up_rem2, 1'b0};
    ge1 = sh1 >= {1'b0, d1};
    ge2 = sh2 >= {1'b0, d2};
    rem1_nxt = ge1 ? eas_pkg::REM_W'(sh1 - {1'b0, d1}) : eas_pkg::REM_W'(sh1);
    rem2_nxt = ge2 ? eas_pkg::REM_W'(sh2 - {1'b0, d2}) : eas_pkg::REM_W'(sh2);
  end

  assign up_ready = !valid_r || dn_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      rem1_r  <= rem1_nxt;
      rem2_r  <= rem2_nxt;
      q1_r    <= {up_q1[QW-2:0], ge1};
      q2_r    <= {up_q2[QW-2:0], ge2};
      flags_r <= up_flags;
    end
  end

  assign dn_valid = valid_r;
  assign dn_rem1  = rem1_r;
  assign dn_rem2  = rem2_r;
  assign dn_q1    = q1_r;
  assign dn_q2    = q2_r;
  assign dn_flags = flags_r;

endmodule

// ----- rtl/core/eas_score.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eas_score
// clamps both ratios, forms the weighted sum and divides by three
// ----------------------------------------------------------------------------
module eas_score #(
  parameter int FRAC_BITS = eas_pkg::FRAC_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                up_valid,
  output logic                up_ready,
  input  logic [FRAC_BITS+1:0] up_q1,
  input  logic [FRAC_BITS+1:0] up_q2,
  input  eas_pkg::eas_flags_t up_flags,
  eas_out_if.source           out_ch
);

  localparam int QW = FRAC_BITS + 2;
  localparam int NW = FRAC_BITS + eas_pkg::SUM_W;
  localparam int PW = eas_pkg::SUM_W + eas_pkg::DIV3_MUL_W;
  localparam logic [QW-1:0] ONE   = QW'(1) << FRAC_BITS;
  localparam logic [QW-1:0] HALF  = ONE >> 1;
  localparam logic [QW-1:0] TWO   = ONE << 1;
  localparam logic [QW-1:0] THREE = ONE + TWO;

  logic [QW-1:0] r1, r2, r1_off;
  logic [NW-1:0] sum;

  // clamped ratios
  always_comb begin
    if (up_flags.tonic_zero) begin
      r1 = ONE;
    end else if (up_flags.tonic_sat) begin
      r1 = TWO;
    end else if (up_q1 < HALF) begin
      r1 = HALF;
    end else begin
      r1 = up_q1;
    end
    if (up_flags.phasic_zero) begin
      r2 = ONE;
    end else if (up_flags.phasic_sat) begin
      r2 = THREE;
    end else begin
      r2 = up_q2;
    end
    r1_off = r1 - HALF;
    sum = NW'(r1_off) * NW'(eas_pkg::W_TONIC) + NW'(r2) * NW'(eas_pkg::W_PHASIC);
  end

  // stage one: integer part of the weighted sum
  logic                         v1_r, rdy1;
  logic [eas_pkg::SUM_W-1:0]    x_r;
  // stage two: output register
  logic                         v2_r, rdy2;
  logic [eas_pkg::ARO_W-1:0]    aro_r;

  logic [PW-1:0]                prod;
  logic [PW-eas_pkg::DIV3_SHIFT-1:0] quo;
  logic [eas_pkg::ARO_W-1:0]    aro_nxt;

  always_comb begin
    prod = PW'(x_r) * PW'(eas_pkg::DIV3_MUL);
    quo  = prod[PW-1:eas_pkg::DIV3_SHIFT];
    if (quo > {1'b0, eas_pkg::SCORE_MAX}) begin
      aro_nxt = eas_pkg::SCORE_MAX;
    end else begin
      aro_nxt = quo[eas_pkg::ARO_W-1:0];
    end
  end

  assign rdy2     = !v2_r || out_ch.ready;
  assign rdy1     = !v1_r || rdy2;
  assign up_ready = rdy1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      if (rdy1) begin
        v1_r <= up_valid;
      end
      if (rdy2) begin
        v2_r <= v1_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1 && up_valid) begin
      x_r <= sum[NW-1:FRAC_BITS];
    end
    if (rdy2 && v1_r) begin
      aro_r <= aro_nxt;
    end
  end

  assign out_ch.valid   = v2_r;
  assign out_ch.arousal = aro_r;

endmodule

// ----- rtl/core/eda_arousal_score.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eda_arousal_score
// arousal score from a tonic skin-conductance level and a phasic response rate
// ----------------------------------------------------------------------------
// usage
//   in_ch carries one sample pair per transfer (tonic_level, phasic_rate);
//   out_ch returns one arousal score 0..100 per sample, in order.
//   baselines are written through cfg_we/cfg_index/cfg_wdata while idle:
//   index 0 tonic baseline, index 1 phasic baseline, others ignored.
//   a zero baseline forces that ratio to one.
// timing
//   a row of FRAC_BITS+2 division cells, one quotient bit each, feeds a
//   two-stage scorer. one sample per cycle sustained while out_ch is not
//   stalled; every cell is a pipeline stage.
// reset
//   rst_n clears all valid bits and both baselines to zero.
// stalls
//   each stage holds when full and the next stage is full and not moving,
//   so bubbles fill up and in_ch.ready drops only once the whole row is
//   full behind a stalled out_ch.
// ----------------------------------------------------------------------------
module eda_arousal_score #(
  parameter int FRAC_BITS = eas_pkg::FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  eas_in_if.sink                        in_ch,
  eas_out_if.source                     out_ch,
  input  logic                          cfg_we,
  input  logic [eas_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [eas_pkg::VAL_W-1:0]     cfg_wdata
);

  // quotient bits: two integer bits plus the fraction
  localparam int NCELL = FRAC_BITS + 2;
  localparam int QW    = FRAC_BITS + 2;

  // baseline registers
  logic [eas_pkg::VAL_W-1:0] tonic_base_r, phasic_base_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tonic_base_r  <= '0;
      phasic_base_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        eas_pkg::REG_TONIC_BASE:  tonic_base_r  <= cfg_wdata;
        eas_pkg::REG_PHASIC_BASE: phasic_base_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // divisor scaled by four so the running remainder starts as the sample
  // itself; NCELL steps then give floor(sample * 2^FRAC_BITS / baseline)
  logic [eas_pkg::REM_W-1:0] d1, d2;
  assign d1 = {tonic_base_r, 2'b00};
  assign d2 = {phasic_base_r, 2'b00};

  // saturation tests done up front, so the cells only need two integer bits
  eas_pkg::eas_flags_t in_flags;
  logic [eas_pkg::REM_W-1:0] base2_x3;

  always_comb begin
    base2_x3 = {2'b00, phasic_base_r} + {1'b0, phasic_base_r, 1'b0};
    in_flags.tonic_zero  = tonic_base_r == '0;
    in_flags.tonic_sat   = {1'b0, in_ch.tonic_level} >= {tonic_base_r, 1'b0};
    in_flags.phasic_zero = phasic_base_r == '0;
    in_flags.phasic_sat  = {2'b00, in_ch.phasic_rate} >= base2_x3;
  end

  // links between neighboring cells; link 0 is the input channel
  logic                      lv   [0:NCELL];
  logic                      lr   [0:NCELL];
  logic [eas_pkg::REM_W-1:0] lrem1[0:NCELL];
  logic [eas_pkg::REM_W-1:0] lrem2[0:NCELL];
  logic [QW-1:0]             lq1  [0:NCELL];
  logic [QW-1:0]             lq2  [0:NCELL];
  eas_pkg::eas_flags_t       lfl  [0:NCELL];

  assign lv[0]    = in_ch.valid;
  assign in_ch.ready = lr[0];
  assign lrem1[0] = {2'b00, in_ch.tonic_level};
  assign lrem2[0] = {2'b00, in_ch.phasic_rate};
  assign lq1[0]   = '0;
  assign lq2[0]   = '0;
  assign lfl[0]   = in_flags;

  for (genvar i = 0; i < NCELL; i++) begin : g_cell
    eas_div_cell #(
      .QW (QW)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .d1       (d1),
      .d2       (d2),
      .up_valid (lv[i]),
      .up_ready (lr[i]),
      .up_rem1  (lrem1[i]),
      .up_rem2  (lrem2[i]),
      .up_q1    (lq1[i]),
      .up_q2    (lq2[i]),
      .up_flags (lfl[i]),
      .dn_valid (lv[i+1]),
      .dn_ready (lr[i+1]),
      .dn_rem1  (lrem1[i+1]),
      .dn_rem2  (lrem2[i+1]),
      .dn_q1    (lq1[i+1]),
      .dn_q2    (lq2[i+1]),
      .dn_flags (lfl[i+1])
    );
  end

  // final remainders are not needed past the last cell
  logic rem_unused;
  assign rem_unused = ^{lrem1[NCELL], lrem2[NCELL]};

  eas_score #(
    .FRAC_BITS (FRAC_BITS)
  ) u_score (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (lv[NCELL] | (rem_unused & 1'b0)),
    .up_ready (lr[NCELL]),
    .up_q1    (lq1[NCELL]),
    .up_q2    (lq2[NCELL]),
    .up_flags (lfl[NCELL]),
    .out_ch   (out_ch)
  );

endmodule
